// ===== hdl/bses_pkg.sv =====
// Shared types, constants and helpers of the bucketed step event store.
`default_nettype none
package bses_pkg;

	localparam int EventDepthDef = 256;
	localparam int StepDepthDef  = 128;
	localparam int LockSlots     = 8;

	localparam logic [3:0] BucketMax   = 4'd15;
	localparam logic [7:0] TrackLenRst = 8'd16;
	localparam logic [6:0] TicksRst    = 7'd12;

	localparam logic [1:0] ACT_ADD    = 2'd0;
	localparam logic [1:0] ACT_REMOVE = 2'd1;
	localparam logic [1:0] ACT_TICK   = 2'd2;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	localparam logic [0:0] REG_TRACK_LENGTH  = 1'd0;
	localparam logic [0:0] REG_TICKS_PER_STEP = 1'd1;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_REMOVE,
		OP_TICK
	} op_t;

	typedef enum logic [2:0] {
		K_ADDED   = 3'd0,
		K_REFUSED = 3'd1,
		K_REMOVED = 3'd2,
		K_IGNORED = 3'd3,
		K_FIRED   = 3'd4,
		K_DONE    = 3'd5
	} kind_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_A_CHK,
		S_A_SCAN,
		S_A_SRCH,
		S_A_SHIFT,
		S_A_FIN,
		S_R_SCAN,
		S_R_SHIFT,
		S_R_FIN,
		S_T_RDN,
		S_T_GOT,
		S_T_RD,
		S_T_CHK,
		S_T_DONE,
		S_EMIT
	} st_t;

	typedef struct packed {
		logic       is_lock;
		logic [2:0] lock_slot;
		logic [6:0] value;
		logic       on;
		logic [6:0] condition;
		logic [7:0] micro;
	} event_t;

	typedef struct packed {
		op_t        op;
		logic [6:0] step;
		logic [7:0] rem;
		event_t     ev;
	} item_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] slot;
		logic [6:0] step;
		logic       is_lock;
		logic [2:0] lock_slot;
		logic [6:0] value;
		logic       on;
		logic [6:0] condition;
		logic       last;
	} res_t;

	typedef struct packed {
		logic [7:0] track_length;
		logic [6:0] ticks_per_step;
	} cfg_t;

	// Lock slot folded into the supported range by repeated subtraction.
	function automatic logic [2:0] lock_mod(input logic [2:0] slot);
		logic [3:0] v;
		v = {1'b0, slot};
		for (int i = 0; i < 8; i++) begin
			if (v >= 4'(LockSlots)) begin
				v = v - 4'(LockSlots);
			end
		end
		return v[2:0];
	endfunction

endpackage
`default_nettype wire

// ===== hdl/bucketed_step_event_store.sv =====
// Top level of the bucketed step event store: configuration, front, back, output register.
//
// A request arrives on the in_valid/in_ready channel: add an event, remove an
// event or play one clock tick. Every request except an unused action code
// yields one or more results on out_valid/out_ready; the final result of each
// request carries last. Configuration (track length, ticks per step) is written
// through cfg_we/cfg_index/cfg_data; the user must write it only while the block
// is idle, as the block itself has no check for this. Requests are classified
// in the front and held in a two-entry queue, so a new request is taken while
// the back end is still working or a result waits. One request at a time is
// carried out by the back-end sequencer:
//   add     check, bucket sum below the target step, search of the bucket, shift up,
//   remove  range check, bucket sum up to the owning step, shift down of later events,
//   tick    check of every event of the two steps played, then the done result.
// Reset empties the store (bucket counts are cleared at once by valid bits) and
// sets length 16 and 12 ticks per step. When the receiver stalls the result
// holds in the output register and the sequencer waits behind it.
`default_nettype none
module bucketed_step_event_store
	import bses_pkg::*;
#(
	parameter int EVENT_DEPTH = EventDepthDef,
	parameter int STEP_DEPTH  = StepDepthDef
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [0:0] cfg_index,
	input  wire logic [7:0] cfg_data,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] action,
	input  wire logic [6:0] target_step,
	input  wire logic [7:0] remove_index,
	input  wire logic       new_is_lock,
	input  wire logic [2:0] new_lock_slot,
	input  wire logic [6:0] new_value,
	input  wire logic       new_on,
	input  wire logic [6:0] new_condition,
	input  wire logic [7:0] new_micro,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [2:0]      kind,
	output logic [7:0]      slot_index,
	output logic [6:0]      fired_step,
	output logic            out_is_lock,
	output logic [2:0]      out_lock_slot,
	output logic [6:0]      out_value,
	output logic            out_on,
	output logic [6:0]      out_condition,
	output logic            last
);

	cfg_t  cfg_q;
	logic  q_valid, q_pop;
	item_t q_item;
	logic  res_valid, res_ready;
	res_t  res, out_q;
	logic  ovld_q;

	// Configuration registers, to be written by the user only while the block is idle (unchecked).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.track_length   <= TrackLenRst;
			cfg_q.ticks_per_step <= TicksRst;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TRACK_LENGTH:   cfg_q.track_length   <= cfg_data;
				REG_TICKS_PER_STEP: cfg_q.ticks_per_step <= cfg_data[6:0];
			endcase
		end
	end

	bses_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.target_step   (target_step),
		.remove_index  (remove_index),
		.new_is_lock   (new_is_lock),
		.new_lock_slot (new_lock_slot),
		.new_value     (new_value),
		.new_on        (new_on),
		.new_condition (new_condition),
		.new_micro     (new_micro),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop)
	);

	bses_back #(
		.EVENT_DEPTH (EVENT_DEPTH),
		.STEP_DEPTH  (STEP_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready)
	);

	// Output register: takes a new result whenever it is empty or being drained.
	assign res_ready = !ovld_q || out_ready;

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if (res_ready) begin
			ovld_q <= res_valid;
		end
	end

	assign out_valid     = ovld_q;
	assign kind          = out_q.kind;
	assign slot_index    = out_q.slot;
	assign fired_step    = out_q.step;
	assign out_is_lock   = out_q.is_lock;
	assign out_lock_slot = out_q.lock_slot;
	assign out_value     = out_q.value;
	assign out_on        = out_q.on;
	assign out_condition = out_q.condition;
	assign last          = out_q.last;

	// A result held back by a full output register must not change.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("back-end result changed while stalled");

	// Only fired events are followed by further results of the same request.
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && !res.last |-> res.kind == K_FIRED)
		else $error("non-final result that is not a fired event");

endmodule
`default_nettype wire

// ===== hdl/bses_front.sv =====
// Front end: accepts requests, classifies them and queues them for the back end.
`default_nettype none
module bses_front
	import bses_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] action,
	input  wire logic [6:0] target_step,
	input  wire logic [7:0] remove_index,
	input  wire logic       new_is_lock,
	input  wire logic [2:0] new_lock_slot,
	input  wire logic [6:0] new_value,
	input  wire logic       new_on,
	input  wire logic [6:0] new_condition,
	input  wire logic [7:0] new_micro,
	output logic            q_valid,
	output item_t           q_item,
	input  wire logic       q_pop
);

	item_t      mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	item_t      item;
	logic       keep, push;

	always_comb begin
		item.step          = target_step;
		item.rem           = remove_index;
		item.ev.is_lock    = new_is_lock;
		item.ev.lock_slot  = lock_mod(new_lock_slot);
		item.ev.value      = new_value;
		item.ev.on         = new_on;
		item.ev.condition  = new_condition;
		item.ev.micro      = new_micro;
		keep    = 1'b1;
		item.op = OP_TICK;
		unique case (action)
			ACT_ADD:    item.op = OP_ADD;
			ACT_REMOVE: item.op = OP_REMOVE;
			ACT_TICK:   item.op = OP_TICK;
			default:    keep = 1'b0;
		endcase
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready && keep;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (q_pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

endmodule
`default_nettype wire

// ===== hdl/bses_back.sv =====
// Back end: sequencer that edits the event and bucket memories and plays ticks.
`default_nettype none
module bses_back
	import bses_pkg::*;
#(
	parameter int EVENT_DEPTH = EventDepthDef,
	parameter int STEP_DEPTH  = StepDepthDef
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	input  wire logic  q_valid,
	input  wire item_t q_item,
	output logic       q_pop,
	output logic       res_valid,
	output res_t       res,
	input  wire logic  res_ready
);

	localparam int EW = $clog2(EVENT_DEPTH);
	localparam int SW = $clog2(STEP_DEPTH);

	// Memories.
	event_t     emem [EVENT_DEPTH];
	logic [3:0] bmem [STEP_DEPTH];
	logic [STEP_DEPTH-1:0] bvld_q;
	event_t     e_rdata_q;
	logic [3:0] b_rdata_q;
	logic       b_rvld_q;
	logic [EW-1:0] e_raddr, e_waddr;
	logic [SW-1:0] b_raddr, b_waddr;
	event_t     e_wdata;
	logic [3:0] b_wdata, b_cnt;
	logic       e_we, b_we;

	always_ff @(posedge clk) begin
		if (e_we) begin
			emem[e_waddr] <= e_wdata;
		end
		e_rdata_q <= emem[e_raddr];
		if (b_we) begin
			bmem[b_waddr] <= b_wdata;
		end
		b_rdata_q <= bmem[b_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bvld_q   <= '0;
			b_rvld_q <= 1'b0;
		end else begin
			if (b_we) begin
				bvld_q[b_waddr] <= 1'b1;
			end
			b_rvld_q <= bvld_q[b_raddr];
		end
	end

	assign b_cnt = b_rvld_q ? b_rdata_q : 4'd0;

	// Sequencer state.
	st_t        st_q, st_d;
	item_t      item_q, item_d;
	res_t       res_q, res_d;
	logic [SW:0] bs_q, bs_d;
	logic [SW-1:0] dstep_q, dstep_d, owner_q, owner_d, pstep_q, pstep_d;
	logic [EW:0] ep_q, ep_d, da_q, da_d, sum_q, sum_d, idx_q, idx_d, end_q, end_d;
	logic [EW:0] total_q, total_d, pidx_q, pidx_d;
	logic [3:0] cnt_q, cnt_d, cntn_q, cntn_d;
	logic [6:0] tick_q, tick_d;
	logic       pend_q, pend_d, phase_q, phase_d;

	logic [SW-1:0] step_a, nxt;
	logic [SW:0]   p1;
	logic          nxt0, match;
	logic [EW:0]   nsum, start1;
	logic [7:0]    mid8, tick8;
	logic [6:0]    tn;

	always_comb begin
		step_a = SW'(item_q.step);
		p1     = (SW+1)'(pstep_q) + 1'b1;
		nxt0   = (16'(p1) >= 16'(cfg.track_length)) || (16'(p1) >= 16'(STEP_DEPTH));
		nxt    = nxt0 ? '0 : p1[SW-1:0];
		nsum   = sum_q + (EW+1)'(b_cnt);
		start1 = nxt0 ? '0 : end_q;
		mid8   = {1'b0, cfg.ticks_per_step};
		tick8  = {1'b0, tick_q};
		if (!phase_q) begin
			match = (e_rdata_q.micro >= mid8) && ((e_rdata_q.micro - mid8) == tick8);
		end else begin
			match = (e_rdata_q.micro < mid8) && (e_rdata_q.micro == tick8);
		end
		tn = tick_q + 7'd1;
	end

	always_comb begin
		st_d    = st_q;
		item_d  = item_q;
		res_d   = res_q;
		bs_d    = bs_q;
		dstep_d = dstep_q;
		owner_d = owner_q;
		pstep_d = pstep_q;
		ep_d    = ep_q;
		da_d    = da_q;
		sum_d   = sum_q;
		idx_d   = idx_q;
		end_d   = end_q;
		total_d = total_q;
		pidx_d  = pidx_q;
		cnt_d   = cnt_q;
		cntn_d  = cntn_q;
		tick_d  = tick_q;
		pend_d  = 1'b0;
		phase_d = phase_q;
		q_pop   = 1'b0;
		res_valid = 1'b0;
		res     = '0;
		b_raddr = bs_q[SW-1:0];
		e_raddr = ep_q[EW-1:0];
		e_we    = 1'b0;
		e_waddr = da_q[EW-1:0];
		e_wdata = e_rdata_q;
		b_we    = 1'b0;
		b_waddr = step_a;
		b_wdata = cnt_q + 4'd1;

		unique case (st_q)
			S_IDLE: begin
				if (q_valid) begin
					q_pop  = 1'b1;
					item_d = q_item;
					bs_d   = '0;
					sum_d  = '0;
					unique case (q_item.op)
						OP_ADD: begin
							b_raddr = SW'(q_item.step);
							st_d    = S_A_CHK;
						end
						OP_REMOVE: begin
							if (16'(q_item.rem) >= 16'(total_q)) begin
								res_d      = '0;
								res_d.kind = K_IGNORED;
								res_d.slot = q_item.rem;
								res_d.last = 1'b1;
								st_d       = S_EMIT;
							end else begin
								st_d = S_R_SCAN;
							end
						end
						OP_TICK: begin
							b_raddr = pstep_q;
							st_d    = S_T_RDN;
						end
						default: st_d = S_IDLE;
					endcase
				end
			end
			S_A_CHK: begin
				if ((16'(item_q.step) >= 16'(STEP_DEPTH)) || (b_cnt >= BucketMax) ||
				    (16'(total_q) >= 16'(EVENT_DEPTH))) begin
					res_d      = '0;
					res_d.kind = K_REFUSED;
					res_d.last = 1'b1;
					st_d       = S_EMIT;
				end else begin
					cnt_d = b_cnt;
					st_d  = S_A_SCAN;
				end
			end
			S_A_SCAN: begin
				// Sum of the buckets below the target step, one read a cycle.
				if (bs_q < (SW+1)'(step_a)) begin
					bs_d   = bs_q + 1'b1;
					pend_d = 1'b1;
				end
				if (pend_q) begin
					sum_d = nsum;
				end else if (bs_q >= (SW+1)'(step_a)) begin
					ep_d  = sum_q;
					end_d = sum_q + (EW+1)'(cnt_q);
					st_d  = S_A_SRCH;
				end
			end
			S_A_SRCH: begin
				// First entry of the step whose timing is not earlier.
				if (ep_q < end_q) begin
					ep_d   = ep_q + 1'b1;
					da_d   = ep_q;
					pend_d = 1'b1;
				end
				if (pend_q && (e_rdata_q.micro >= item_q.ev.micro)) begin
					idx_d  = da_q;
					ep_d   = total_q;
					pend_d = 1'b0;
					st_d   = S_A_SHIFT;
				end else if (!pend_q && (ep_q >= end_q)) begin
					idx_d  = end_q;
					ep_d   = total_q;
					pend_d = 1'b0;
					st_d   = S_A_SHIFT;
				end
			end
			S_A_SHIFT: begin
				if (ep_q > idx_q) begin
					e_raddr = EW'(ep_q - 1'b1);
					ep_d    = ep_q - 1'b1;
					da_d    = ep_q;
					pend_d  = 1'b1;
				end
				if (pend_q) begin
					e_we    = 1'b1;
				end else if (ep_q <= idx_q) begin
					st_d = S_A_FIN;
				end
			end
			S_A_FIN: begin
				e_we    = 1'b1;
				e_waddr = idx_q[EW-1:0];
				e_wdata = item_q.ev;
				b_we    = 1'b1;
				if (step_a < pstep_q) begin
					pidx_d = pidx_q + 1'b1;
				end
				total_d    = total_q + 1'b1;
				res_d      = '0;
				res_d.kind = K_ADDED;
				res_d.slot = 8'(idx_q);
				res_d.last = 1'b1;
				st_d       = S_EMIT;
			end
			S_R_SCAN: begin
				// Running bucket sum until it passes the index.
				if (bs_q < (SW+1)'(STEP_DEPTH)) begin
					bs_d    = bs_q + 1'b1;
					dstep_d = bs_q[SW-1:0];
					pend_d  = 1'b1;
				end
				if (pend_q) begin
					if (16'(nsum) > 16'(item_q.rem)) begin
						owner_d = dstep_q;
						cnt_d   = b_cnt;
						ep_d    = (EW+1)'(item_q.rem) + 1'b1;
						pend_d  = 1'b0;
						st_d    = S_R_SHIFT;
					end else begin
						sum_d = nsum;
					end
				end else if (bs_q >= (SW+1)'(STEP_DEPTH)) begin
					res_d      = '0;
					res_d.kind = K_IGNORED;
					res_d.slot = item_q.rem;
					res_d.last = 1'b1;
					st_d       = S_EMIT;
				end
			end
			S_R_SHIFT: begin
				if (ep_q < total_q) begin
					ep_d   = ep_q + 1'b1;
					da_d   = ep_q;
					pend_d = 1'b1;
				end
				if (pend_q) begin
					e_we    = 1'b1;
					e_waddr = EW'(da_q - 1'b1);
				end else if (ep_q >= total_q) begin
					st_d = S_R_FIN;
				end
			end
			S_R_FIN: begin
				b_we    = 1'b1;
				b_waddr = owner_q;
				b_wdata = cnt_q - 4'd1;
				if (owner_q < pstep_q) begin
					pidx_d = pidx_q - 1'b1;
				end
				total_d    = total_q - 1'b1;
				res_d      = '0;
				res_d.kind = K_REMOVED;
				res_d.slot = item_q.rem;
				res_d.last = 1'b1;
				st_d       = S_EMIT;
			end
			S_T_RDN: begin
				cnt_d   = b_cnt;
				b_raddr = nxt;
				st_d    = S_T_GOT;
			end
			S_T_GOT: begin
				cntn_d  = b_cnt;
				ep_d    = pidx_q;
				end_d   = pidx_q + (EW+1)'(cnt_q);
				phase_d = 1'b0;
				st_d    = S_T_RD;
			end
			S_T_RD: begin
				if (ep_q < end_q) begin
					st_d = S_T_CHK;
				end else if (!phase_q) begin
					phase_d = 1'b1;
					ep_d    = start1;
					end_d   = start1 + (EW+1)'(cntn_q);
				end else begin
					st_d = S_T_DONE;
				end
			end
			S_T_CHK: begin
				if (match) begin
					res_valid     = 1'b1;
					res.kind      = K_FIRED;
					res.slot      = 8'(ep_q);
					res.step      = phase_q ? 7'(nxt) : 7'(pstep_q);
					res.is_lock   = e_rdata_q.is_lock;
					res.lock_slot = e_rdata_q.lock_slot;
					res.value     = e_rdata_q.value;
					res.on        = e_rdata_q.on;
					res.condition = e_rdata_q.condition;
					if (res_ready) begin
						ep_d = ep_q + 1'b1;
						st_d = S_T_RD;
					end
				end else begin
					ep_d = ep_q + 1'b1;
					st_d = S_T_RD;
				end
			end
			S_T_DONE: begin
				res_valid = 1'b1;
				res.kind  = K_DONE;
				res.last  = 1'b1;
				if (res_ready) begin
					if (tn >= cfg.ticks_per_step) begin
						tick_d  = '0;
						pidx_d  = nxt0 ? '0 : (pidx_q + (EW+1)'(cnt_q));
						pstep_d = nxt;
					end else begin
						tick_d = tn;
					end
					st_d = S_IDLE;
				end
			end
			S_EMIT: begin
				res_valid = 1'b1;
				res       = res_q;
				if (res_ready) begin
					st_d = S_IDLE;
				end
			end
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		item_q  <= item_d;
		res_q   <= res_d;
		dstep_q <= dstep_d;
		owner_q <= owner_d;
		ep_q    <= ep_d;
		da_q    <= da_d;
		sum_q   <= sum_d;
		idx_q   <= idx_d;
		end_q   <= end_d;
		bs_q    <= bs_d;
		cnt_q   <= cnt_d;
		cntn_q  <= cntn_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_IDLE;
			total_q <= '0;
			pidx_q  <= '0;
			pstep_q <= '0;
			tick_q  <= '0;
			pend_q  <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			st_q    <= st_d;
			total_q <= total_d;
			pidx_q  <= pidx_d;
			pstep_q <= pstep_d;
			tick_q  <= tick_d;
			pend_q  <= pend_d;
			phase_q <= phase_d;
		end
	end

endmodule
`default_nettype wire

// ===== dv/tb_bucketed_step_event_store.sv =====
// Self-checking testbench for the bucketed step event store.
`timescale 1ns / 100ps

// Scoreboard: keeps its own copy of the event store and works out the results
// of every accepted request. Results from the block are then checked against them.
class step_store_scoreboard;
	bses_pkg::event_t stored_events[256];
	int unsigned bucket_fill[128];
	int unsigned event_total, play_pos, play_at, sub_tick;
	int unsigned loop_steps, tick_span;
	int unsigned mismatches;
	bses_pkg::res_t expected_results[$];

	function new();
		event_total = 0; play_pos = 0; play_at = 0; sub_tick = 0;
		loop_steps = 16; tick_span = 12; mismatches = 0;
		foreach (bucket_fill[s]) bucket_fill[s] = 0;
		foreach (stored_events[i]) stored_events[i] = '0;
	endfunction

	function void set_register(logic [0:0] index, logic [7:0] data);
		if (index == bses_pkg::REG_TRACK_LENGTH)
			loop_steps = 32'(data);
		else
			tick_span = 32'(data[6:0]);
	endfunction

	function int unsigned pending();
		return expected_results.size();
	endfunction

	function int unsigned step_after(int unsigned step);
		if (step + 1 >= loop_steps || step + 1 >= 128)
			return 0;
		return step + 1;
	endfunction

	function void push_simple(bses_pkg::kind_t k, logic [7:0] slot);
		bses_pkg::res_t r;
		r = '0;
		r.kind = k;
		r.slot = slot;
		r.last = 1'b1;
		expected_results.push_back(r);
	endfunction

	function void push_fired(int unsigned idx, int unsigned step);
		bses_pkg::res_t r;
		r = '0;
		r.kind = bses_pkg::K_FIRED;
		r.slot = idx[7:0];
		r.step = step[6:0];
		r.is_lock = stored_events[idx].is_lock;
		r.lock_slot = stored_events[idx].lock_slot;
		r.value = stored_events[idx].value;
		r.on = stored_events[idx].on;
		r.condition = stored_events[idx].condition;
		expected_results.push_back(r);
	endfunction

	// Called for every accepted request.
	function void note_request(logic [1:0] act, logic [6:0] step, logic [7:0] rem,
			bses_pkg::event_t ev);
		int unsigned idx, stop, s, sum, mid, cur, nxt, u;
		if (act == bses_pkg::ACT_ADD) begin
			ev.lock_slot = 3'(ev.lock_slot % bses_pkg::LockSlots);
			if (bucket_fill[step] >= 15 || event_total >= 256) begin
				push_simple(bses_pkg::K_REFUSED, 8'd0);
				return;
			end
			idx = 0;
			for (s = 0; s < step; s++) idx += bucket_fill[s];
			stop = idx + bucket_fill[step];
			while (idx < stop && stored_events[idx].micro < ev.micro) idx++;
			for (int unsigned i = event_total; i > idx; i--)
				stored_events[i] = stored_events[i - 1];
			stored_events[idx] = ev;
			bucket_fill[step]++;
			if (step < play_at) play_pos++;
			event_total++;
			push_simple(bses_pkg::K_ADDED, idx[7:0]);
		end else if (act == bses_pkg::ACT_REMOVE) begin
			if (rem >= event_total) begin
				push_simple(bses_pkg::K_IGNORED, rem);
				return;
			end
			sum = 0;
			for (s = 0; s < 128; s++) begin
				sum += bucket_fill[s];
				if (sum > rem) break;
			end
			bucket_fill[s]--;
			for (int unsigned i = rem; i + 1 < event_total; i++)
				stored_events[i] = stored_events[i + 1];
			if (s < play_at) play_pos--;
			event_total--;
			push_simple(bses_pkg::K_REMOVED, rem);
		end else if (act == bses_pkg::ACT_TICK) begin
			mid = tick_span;
			cur = play_at < 128 ? play_at : 0;
			nxt = step_after(cur);
			// Late events of the current step first.
			stop = play_pos + bucket_fill[cur];
			for (idx = play_pos; idx < stop && idx < 256; idx++) begin
				u = 32'(stored_events[idx].micro);
				if (u >= mid && u - mid == sub_tick) push_fired(idx, cur);
			end
			// Then early events of the next step, which restarts at 0 on a wrap.
			idx = (nxt == 0) ? 0 : stop;
			stop = idx + bucket_fill[nxt];
			for (; idx < stop && idx < 256; idx++) begin
				u = 32'(stored_events[idx].micro);
				if (u < mid && u == sub_tick) push_fired(idx, nxt);
			end
			push_simple(bses_pkg::K_DONE, 8'd0);
			sub_tick = (sub_tick + 1) & 32'h7f;
			if (sub_tick >= mid) begin
				sub_tick = 0;
				play_pos = (nxt == 0) ? 0 : play_pos + bucket_fill[cur];
				play_at = nxt;
			end
		end
	endfunction

	function void compare_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	// Called for every accepted result.
	function void check_result(bses_pkg::res_t got);
		bses_pkg::res_t want;
		if (expected_results.size() == 0) begin
			mismatches++;
			$display("%0t: result kind %0d with nothing expected", $time, got.kind);
			return;
		end
		want = expected_results.pop_front();
		compare_field("kind", want.kind, got.kind);
		compare_field("slot_index", want.slot, got.slot);
		compare_field("fired_step", want.step, got.step);
		compare_field("out_is_lock", want.is_lock, got.is_lock);
		compare_field("out_lock_slot", want.lock_slot, got.lock_slot);
		compare_field("out_value", want.value, got.value);
		compare_field("out_on", want.on, got.on);
		compare_field("out_condition", want.condition, got.condition);
		compare_field("last", want.last, got.last);
	endfunction
endclass

module tb_bucketed_step_event_store;
	import bses_pkg::*;

	// Settling allowance, well over the longest request (a full-depth add).
	localparam int SettleCycles = 600;
	localparam int StallLimit   = 20000;
	localparam int HoldCycles   = 400;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [0:0] cfg_index;
	logic [7:0] cfg_data;
	logic in_valid, in_ready;
	logic [1:0] action;
	logic [6:0] target_step;
	logic [7:0] remove_index;
	logic new_is_lock;
	logic [2:0] new_lock_slot;
	logic [6:0] new_value;
	logic new_on;
	logic [6:0] new_condition;
	logic [7:0] new_micro;
	logic out_valid, out_ready;
	logic [2:0] kind;
	logic [7:0] slot_index;
	logic [6:0] fired_step;
	logic out_is_lock;
	logic [2:0] out_lock_slot;
	logic [6:0] out_value;
	logic out_on;
	logic [6:0] out_condition;
	logic last;

	step_store_scoreboard store_model;
	int unsigned sender_idle_pct, receiver_idle_pct;
	bit hold_receiver;
	int unsigned quiet_cycles = 0;

	bucketed_step_event_store dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: random stalls, plus one long hold-off on request so that the
	// block fills its queue and pushes back on the sender.
	initial begin
		bit hold_taken;
		hold_taken = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_receiver && !hold_taken) begin
				hold_taken = 1'b1;
				out_ready = 1'b0;
				repeat (HoldCycles) @(negedge clk);
			end
			out_ready = ($urandom_range(99) >= receiver_idle_pct);
		end
	end

	// Monitor: the scoreboard sees requests and results at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				store_model.note_request(action, target_step, remove_index,
					{new_is_lock, new_lock_slot, new_value, new_on, new_condition, new_micro});
			if (out_valid && out_ready)
				store_model.check_result({kind, slot_index, fired_step, out_is_lock,
					out_lock_slot, out_value, out_on, out_condition, last});
		end
	end

	// Watchdog: a run with no handshake for too long has hung.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= StallLimit) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Offers one request and waits for it to be taken.
	task automatic send_request(logic [1:0] act, logic [6:0] step, logic [7:0] rem,
			event_t ev);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		action = act;
		target_step = step;
		remove_index = rem;
		{new_is_lock, new_lock_slot, new_value, new_on, new_condition, new_micro} = ev;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic offer_add(logic [6:0] step, logic [7:0] micro);
		event_t ev;
		ev = 27'($urandom);
		ev.micro = micro;
		send_request(ACT_ADD, step, 8'd0, ev);
	endtask

	// Lets every expected result arrive and the sequencer go quiet.
	task automatic drain();
		in_valid = 1'b0;
		while (store_model.pending() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_register(logic [0:0] index, logic [7:0] data);
		cfg_we = 1'b1;
		cfg_index = index;
		cfg_data = data;
		store_model.set_register(index, data);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// A random mix of adds, removes and ticks. Steps and timings are biased
	// towards the live part of the loop so that ticks actually fire events.
	task automatic random_phase(int unsigned count, int unsigned add_pct,
			int unsigned remove_pct, int unsigned hold_at);
		int unsigned pick, span, mid;
		logic [1:0] act;
		logic [6:0] step;
		logic [7:0] rem;
		event_t ev;
		for (int unsigned n = 0; n < count; n++) begin
			if (n == hold_at) hold_receiver = 1'b1;
			pick = $urandom_range(99);
			if (pick < 2) act = ACT_UNUSED;
			else if (pick < add_pct) act = ACT_ADD;
			else if (pick < add_pct + remove_pct) act = ACT_REMOVE;
			else act = ACT_TICK;
			span = store_model.loop_steps;
			if (span == 0) span = 1;
			if (span > 128) span = 128;
			step = ($urandom_range(9) < 8) ? 7'($urandom_range(span - 1))
				: 7'($urandom_range(127));
			if ($urandom_range(9) < 8 && store_model.event_total > 0)
				rem = 8'($urandom_range(store_model.event_total - 1));
			else
				rem = 8'($urandom_range(255));
			ev = 27'($urandom);
			mid = store_model.tick_span;
			if ($urandom_range(9) < 6)
				ev.micro = 8'($urandom_range((2 * mid + 1 > 255) ? 255 : 2 * mid + 1));
			send_request(act, step, rem, ev);
		end
	endtask

	initial begin
		store_model = new();
		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		hold_receiver = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_TRACK_LENGTH;
		cfg_data = '0;
		in_valid = 1'b0;
		action = ACT_TICK;
		target_step = '0;
		remove_index = '0;
		{new_is_lock, new_lock_slot, new_value, new_on, new_condition, new_micro} = '0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part at the reset settings: an empty tick, ordering on
		// equal and extreme timings, an event on the step and early in the
		// next one, a step past the loop end, an unused action, removes in
		// and out of range, then one bucket filled until it refuses.
		send_request(ACT_TICK, 7'd0, 8'd0, '0);
		offer_add(7'd0, 8'd12);
		offer_add(7'd0, 8'd0);
		offer_add(7'd0, 8'd255);
		offer_add(7'd0, 8'd12);
		offer_add(7'd1, 8'd1);
		offer_add(7'd127, 8'd12);
		send_request(ACT_ADD, 7'd15, 8'd0, '1);
		send_request(ACT_UNUSED, 7'd0, 8'd0, '0);
		send_request(ACT_REMOVE, 7'd0, 8'd255, '0);
		send_request(ACT_TICK, 7'd0, 8'd0, '0);
		send_request(ACT_TICK, 7'd0, 8'd0, '0);
		send_request(ACT_REMOVE, 7'd0, 8'd0, '0);
		for (int i = 0; i < 16; i++) offer_add(7'd3, 8'($urandom));
		drain();

		// Short loop, few ticks per step; sender idles lightly, receiver heavily.
		write_register(REG_TRACK_LENGTH, 8'd8);
		write_register(REG_TICKS_PER_STEP, 8'd4);
		sender_idle_pct = 18;
		receiver_idle_pct = 49;
		random_phase(130, 45, 25, 1000);
		drain();

		// Single-step loop, one tick per step; the top data bit is dropped.
		write_register(REG_TRACK_LENGTH, 8'd1);
		write_register(REG_TICKS_PER_STEP, 8'h81);
		sender_idle_pct = 49;
		receiver_idle_pct = 18;
		random_phase(100, 50, 20, 1000);
		drain();

		// Longest loop and step; mostly adds to fill the store, with a long
		// receiver hold-off while requests keep coming.
		write_register(REG_TRACK_LENGTH, 8'd128);
		write_register(REG_TICKS_PER_STEP, 8'd127);
		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		random_phase(100, 92, 4, 40);
		drain();

		// Length beyond the step range and a zero step length.
		write_register(REG_TRACK_LENGTH, 8'd255);
		write_register(REG_TICKS_PER_STEP, 8'd0);
		random_phase(30, 30, 40, 1000);
		drain();

		// Zero length wraps every step to the start.
		write_register(REG_TRACK_LENGTH, 8'd0);
		write_register(REG_TICKS_PER_STEP, 8'd2);
		random_phase(30, 30, 30, 1000);
		drain();

		if (store_model.mismatches == 0 && store_model.pending() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
